FILE: rtl/core/life_grid_generation_step_top_defines.svh
// assertion macros for the life grid generation step block
`ifndef LIFE_GRID_GENERATION_STEP_TOP_DEFINES_SVH
`define LIFE_GRID_GENERATION_STEP_TOP_DEFINES_SVH

// clocked check, quiet during reset
`define LGS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// single-cycle condition check
`define LGS_CHECK(lbl, cond, msg) \
  `LGS_ASSERT(lbl, (cond), msg)

`endif

FILE: rtl/core/lgs_pkg.sv
// types and constants shared by the life grid generation step block
package lgs_pkg;

  localparam int COL_POS_W = 8;
  localparam int ROW_POS_W = 7;
  localparam int GRID_WIDTH_W = 9;
  localparam int GRID_HEIGHT_W = 8;
  localparam int SIZE_W = 16;

  localparam logic [GRID_WIDTH_W-1:0] GRID_WIDTH_RESET = 9'd130;
  localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RESET = 8'd100;

  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] KEEP_COUNT = 4'd2;

  localparam logic REG_GRID_WIDTH = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SET   = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [COL_POS_W-1:0] col_pos;
    logic [ROW_POS_W-1:0] row_pos;
  } item_t;

  typedef struct packed {
    logic cell_alive;
    logic out_of_range;
  } result_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR,
    ST_RD,
    ST_MOD,
    ST_ADV_RD,
    ST_ADV_SH,
    ST_ADV_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic item_load;
    logic row_clr;
    logic row_inc;
    logic rd_item;
    logic rd_row;
    logic wr_zero;
    logic wr_set;
    logic wr_gen;
    logic buf_clr;
    logic buf_shift;
    logic alive_cap;
    logic res_load;
  } dp_ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       oor;
    logic       row_last;
    logic       adv_first;
    logic       adv_end;
    logic       out_free;
  } dp_sts_t;

endpackage

FILE: rtl/core/lgs_ctrl.sv
// controller state machine for the life grid generation step block
`include "life_grid_generation_step_top_defines.svh"
module lgs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  lgs_pkg::dp_sts_t sts,
  output lgs_pkg::dp_ctl_t ctl
);
  import lgs_pkg::*;

  state_t state, state_next;
  state_t dispatch;
  logic   first_cycle;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // command dispatch after the item is latched
  always_comb begin
    case (sts.cmd)
      CMD_CLEAR: dispatch = ST_CLR;
      CMD_STEP:  dispatch = ST_ADV_RD;
      default:   dispatch = ST_RD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_cycle <= 1'b0;
    end else begin
      first_cycle <= ctl.item_load;
    end
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    item_ready = 1'b0;
    case (state)
      ST_INIT: begin
        ctl.wr_zero = 1'b1;
        ctl.row_inc = 1'b1;
        if (sts.row_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          ctl.item_load = 1'b1;
          ctl.row_clr = 1'b1;
          ctl.buf_clr = 1'b1;
          state_next = ST_ADV_RD;
        end
      end
      ST_CLR: begin
        ctl.wr_zero = 1'b1;
        ctl.row_inc = 1'b1;
        if (sts.row_last) begin
          state_next = ST_DONE;
        end
      end
      ST_RD: begin
        if (sts.oor) begin
          state_next = ST_DONE;
        end else begin
          ctl.rd_item = 1'b1;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (sts.cmd == CMD_SET) begin
          ctl.wr_set = 1'b1;
        end else begin
          ctl.alive_cap = 1'b1;
        end
        state_next = ST_DONE;
      end
      ST_ADV_RD: begin
        if (sts.adv_end && sts.adv_first) begin
          state_next = ST_DONE;
        end else begin
          ctl.rd_row = !sts.adv_end;
          state_next = ST_ADV_SH;
        end
      end
      ST_ADV_SH: begin
        ctl.buf_shift = 1'b1;
        state_next = ST_ADV_WR;
      end
      ST_ADV_WR: begin
        ctl.wr_gen = !sts.adv_first;
        if (sts.adv_end) begin
          state_next = ST_DONE;
        end else begin
          ctl.row_inc = 1'b1;
          state_next = ST_ADV_RD;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          ctl.res_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // dispatch on the newly latched command
    if (state == ST_ADV_RD && first_cycle && dispatch != ST_ADV_RD) begin
      ctl = '0;
      state_next = dispatch;
    end
  end

  `LGS_ASSERT(a_res_slot, ctl.res_load |-> sts.out_free, "result loaded into a full slot")
  `LGS_CHECK(a_one_write, $onehot0({ctl.wr_zero, ctl.wr_set, ctl.wr_gen}),
    "more than one grid write")
  `LGS_ASSERT(a_busy_after_accept, item_valid && item_ready |=> !item_ready,
    "item taken while busy")

endmodule

FILE: rtl/core/lgs_datapath.sv
// grid memory, row buffers, generation lanes and result register
module lgs_datapath #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lgs_pkg::item_t                    item,
  input  logic [lgs_pkg::GRID_WIDTH_W-1:0]  grid_width,
  input  logic [lgs_pkg::GRID_HEIGHT_W-1:0] grid_height,
  input  lgs_pkg::dp_ctl_t                  ctl,
  output lgs_pkg::dp_sts_t                  sts,
  output logic                              result_valid,
  input  logic                              result_ready,
  output lgs_pkg::result_t                  result
);
  import lgs_pkg::*;

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int KW = $clog2(MAX_ROWS + 1);
  localparam int ICW = (CW > COL_POS_W) ? CW : COL_POS_W;
  localparam int IRW = (RW > ROW_POS_W) ? RW : ROW_POS_W;

  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_COLS-1:0] rd_data;
  logic [MAX_COLS-1:0] prev_row, cur_row, nxt_row, gen_row, col_mask;
  logic [MAX_COLS-1:0] pm, cm, nm, set_row;
  item_t               held;
  logic [KW-1:0]       row_cnt;
  logic [KW-1:0]       row_dec;
  logic [SIZE_W-1:0]   used_cols, used_rows;
  logic [ICW-1:0]      colx;
  logic [IRW-1:0]      rowx;
  logic                alive;
  logic                is_access;
  logic                wr_en;
  logic [RW-1:0]       wr_addr, rd_addr;
  logic [MAX_COLS-1:0] wr_data;

  always_comb begin
    used_cols = (SIZE_W'(grid_width) > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS)
                                                          : SIZE_W'(grid_width);
    used_rows = (SIZE_W'(grid_height) > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS)
                                                           : SIZE_W'(grid_height);
  end

  assign colx = ICW'(held.col_pos);
  assign rowx = IRW'(held.row_pos);
  assign row_dec = row_cnt - 1'b1;
  assign is_access = (held.cmd == CMD_SET) || (held.cmd == CMD_READ);

  assign sts.cmd = held.cmd;
  assign sts.oor = is_access && ((SIZE_W'(held.col_pos) >= used_cols) ||
                                 (SIZE_W'(held.row_pos) >= used_rows));
  assign sts.row_last = (row_cnt == KW'(MAX_ROWS - 1));
  assign sts.adv_first = (row_cnt == '0);
  assign sts.adv_end = (SIZE_W'(row_cnt) == used_rows);
  assign sts.out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
    end else if (ctl.row_clr) begin
      row_cnt <= '0;
    end else if (ctl.row_inc) begin
      row_cnt <= sts.row_last && !ctl.wr_gen && !ctl.buf_shift && ctl.wr_zero ? '0
                                                                               : row_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.item_load) begin
      held <= item;
    end
  end

  // grid memory, one row per word
  always_comb begin
    set_row = rd_data;
    set_row[colx[CW-1:0]] = 1'b1;
    wr_en = ctl.wr_zero || ctl.wr_set || ctl.wr_gen;
    wr_addr = row_cnt[RW-1:0];
    wr_data = '0;
    if (ctl.wr_set) begin
      wr_addr = rowx[RW-1:0];
      wr_data = set_row;
    end else if (ctl.wr_gen) begin
      wr_addr = row_dec[RW-1:0];
      wr_data = gen_row;
    end
    rd_addr = ctl.rd_item ? rowx[RW-1:0] : row_cnt[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_item || ctl.rd_row) begin
      rd_data <= mem[rd_addr];
    end
  end

  // row window for the generation sweep
  always_ff @(posedge clk) begin
    if (ctl.buf_clr) begin
      prev_row <= '0;
      cur_row <= '0;
      nxt_row <= '0;
    end else if (ctl.buf_shift) begin
      prev_row <= cur_row;
      cur_row <= nxt_row;
      nxt_row <= sts.adv_end ? '0 : rd_data;
    end
  end

  assign pm = prev_row & col_mask;
  assign cm = cur_row & col_mask;
  assign nm = nxt_row & col_mask;

  for (genvar i = 0; i < MAX_COLS; i++) begin : g_lane
    logic [2:0] lb, rb;
    logic [3:0] cnt;
    assign col_mask[i] = (SIZE_W'(i) < used_cols);
    if (i == 0) begin : g_lo
      assign lb = '0;
    end else begin : g_lm
      assign lb = {pm[i-1], cm[i-1], nm[i-1]};
    end
    if (i == MAX_COLS - 1) begin : g_hi
      assign rb = '0;
    end else begin : g_rm
      assign rb = {pm[i+1], cm[i+1], nm[i+1]};
    end
    assign cnt = 4'(lb[0]) + 4'(lb[1]) + 4'(lb[2]) + 4'(rb[0]) + 4'(rb[1]) + 4'(rb[2]) +
                 4'(pm[i]) + 4'(nm[i]);
    assign gen_row[i] = col_mask[i] ? ((cnt == BIRTH_COUNT) || (cur_row[i] && cnt == KEEP_COUNT))
                                    : cur_row[i];
  end

  always_ff @(posedge clk) begin
    if (ctl.item_load) begin
      alive <= 1'b0;
    end else if (ctl.alive_cap) begin
      alive <= rd_data[colx[CW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.res_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      result.cell_alive <= alive;
      result.out_of_range <= sts.oor;
    end
  end

endmodule

FILE: rtl/core/life_grid_generation_step_top.sv
// top level of the life grid generation step block
// Game of Life (birth on 3, survival on 2 or 3) on a bounded grid of up to MAX_ROWS x MAX_COLS
// cells, stored one row per memory word. Items are taken one at a time. Clear sweeps every row,
// one per cycle. Set and read do a row read, then a row write or bit pick. Advance walks the
// used rows through a three-row window with all columns of a row updated together, each used
// row passing through a read, a shift and a write state. After reset the grid is cleared in a
// pass over all MAX_ROWS rows during which no item is taken; register writes are taken as ever.
// Each result waits in an output register until its transfer.
module life_grid_generation_step_top #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             item_valid,
  output logic             item_ready,
  input  lgs_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output lgs_pkg::result_t result
);
  import lgs_pkg::*;

  logic [GRID_WIDTH_W-1:0]  grid_width;
  logic [GRID_HEIGHT_W-1:0] grid_height;
  dp_ctl_t                  ctl;
  dp_sts_t                  sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= GRID_WIDTH_RESET;
      grid_height <= GRID_HEIGHT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_GRID_WIDTH) begin
        grid_width <= pwdata[GRID_WIDTH_W-1:0];
      end else begin
        grid_height <= pwdata[GRID_HEIGHT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_GRID_HEIGHT) begin
      prdata = 32'(grid_height);
    end else begin
      prdata = 32'(grid_width);
    end
  end

  lgs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sts        (sts),
    .ctl        (ctl)
  );

  lgs_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .grid_width   (grid_width),
    .grid_height  (grid_height),
    .ctl          (ctl),
    .sts          (sts),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
